>>> rtl/opu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opu_pkg
// Shared types, widths and constants of the orbit position update block:
// request and response beats, pipeline sideband and the CORDIC arctangents.
// ----------------------------------------------------------------------------
package opu_pkg;

   localparam int ANGLE_BITS      = 16;
   localparam int POS_BITS        = 24;
   localparam int SPEED_BITS      = 24;
   localparam int TIME_BITS       = 16;
   localparam int RADIUS_BITS     = 16;

   localparam int PHASE_BITS      = 32;
   localparam int CORDIC_ITERS    = 16;
   localparam int ITERS_PER_STAGE = 2;
   localparam int CORDIC_STAGES   = CORDIC_ITERS / ITERS_PER_STAGE;
   localparam int ITER_IDX_W      = $clog2(CORDIC_ITERS);
   localparam int LATENCY         = CORDIC_STAGES + 3;

   // datapath widths: start vector is Q16.16, growth from the CORDIC gain
   localparam int GAIN_BITS       = 30;
   localparam int GAIN_SHIFT      = 14;
   localparam int PROD_BITS       = RADIUS_BITS + GAIN_BITS;
   localparam int X0_BITS         = PROD_BITS - GAIN_SHIFT;
   localparam int CW              = X0_BITS + 3;
   localparam int ZW              = PHASE_BITS + 2;
   localparam int FRAC_SHIFT      = 16;
   localparam int OW              = CW - FRAC_SHIFT;
   localparam int SW              = POS_BITS + 2;

   localparam logic [GAIN_BITS-1:0] GAIN_INV_Q30 = GAIN_BITS'(652032874);
   localparam logic [CW-1:0]        ROUND_HALF   = CW'(32768);

   typedef struct packed {
      logic                          parent_present;
      logic                          already_pending;
      logic signed [POS_BITS-1:0]    parent_x;
      logic signed [POS_BITS-1:0]    parent_y;
      logic        [ANGLE_BITS-1:0]  current_angle;
      logic signed [SPEED_BITS-1:0]  orbit_speed;
      logic        [TIME_BITS-1:0]   delta_time;
      logic        [RADIUS_BITS-1:0] orbit_radius;
   } req_type;

   typedef struct packed {
      logic        [ANGLE_BITS-1:0]  new_angle;
      logic signed [POS_BITS-1:0]    new_x;
      logic signed [POS_BITS-1:0]    new_y;
      logic                          position_valid;
      logic                          request_destroy;
   } rsp_type;

   typedef struct packed {
      logic                          present;
      logic                          pending;
      logic        [ANGLE_BITS-1:0]  angle;
      logic signed [POS_BITS-1:0]    px;
      logic signed [POS_BITS-1:0]    py;
   } side_type;

   function automatic logic [PHASE_BITS-1:0] cordic_atan(input logic [ITER_IDX_W-1:0] idx);
      logic [PHASE_BITS-1:0] r;
      case (idx)
         4'd0:    r = 32'd536870912;
         4'd1:    r = 32'd316933406;
         4'd2:    r = 32'd167458907;
         4'd3:    r = 32'd85004756;
         4'd4:    r = 32'd42667331;
         4'd5:    r = 32'd21354465;
         4'd6:    r = 32'd10679838;
         4'd7:    r = 32'd5340245;
         4'd8:    r = 32'd2670163;
         4'd9:    r = 32'd1335087;
         4'd10:   r = 32'd667544;
         4'd11:   r = 32'd333772;
         4'd12:   r = 32'd166886;
         4'd13:   r = 32'd83443;
         4'd14:   r = 32'd41722;
         4'd15:   r = 32'd20861;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/orbit_position_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orbit_position_update
// Advances one orbiting body per beat and, if its parent is present, places
// it on a circle around that parent with a pipelined CORDIC.
//
// Request channel: req_data carries one body; a beat is taken at a rising
// edge where start is high and busy is low. busy is high only during reset,
// so a new beat may enter in every cycle.
// Response channel: rsp_data is valid for exactly one cycle while rsp_strobe
// is high; the receiver has no way to hold it off, so nothing ever stalls.
// Pipeline: a request passes in order through the input multiply, the angle
// fold, eight CORDIC stages of two rotations each, then rounding and
// saturation, each step registered. Throughput: one beat per cycle outside
// reset, set by the fully pipelined CORDIC.
// Reset: clears all valid bits, so beats in flight are dropped and no
// response follows them.
// ----------------------------------------------------------------------------
module orbit_position_update
   import opu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   logic                         accept;

   logic signed [SPEED_BITS+TIME_BITS:0] prod_in;
   logic [PROD_BITS-1:0]         gain_in;

   logic                         s1_valid_ff;
   side_type                     s1_side_ff;
   side_type                     s1_side_in;
   logic [ANGLE_BITS-1:0]        s1_step_ff;
   logic [X0_BITS-1:0]           s1_x0_ff;

   logic [ANGLE_BITS-1:0]        na;
   logic [PHASE_BITS-1:0]        phase;
   logic                         flip;
   logic [PHASE_BITS-1:0]        z_fold;
   logic signed [CW-1:0]         x_pos;

   logic                         c_valid_ff [CORDIC_STAGES+1];
   logic                         c_valid_in [CORDIC_STAGES+1];
   side_type                     c_side_ff  [CORDIC_STAGES+1];
   side_type                     c_side_in  [CORDIC_STAGES+1];
   logic signed [CW-1:0]         c_x_ff     [CORDIC_STAGES+1];
   logic signed [CW-1:0]         c_x_in     [CORDIC_STAGES+1];
   logic signed [CW-1:0]         c_y_ff     [CORDIC_STAGES+1];
   logic signed [CW-1:0]         c_y_in     [CORDIC_STAGES+1];
   logic signed [ZW-1:0]         c_z_ff     [CORDIC_STAGES+1];
   logic signed [ZW-1:0]         c_z_in     [CORDIC_STAGES+1];

   logic signed [CW-1:0]         xr;
   logic signed [CW-1:0]         yr;
   logic signed [OW-1:0]         ox;
   logic signed [OW-1:0]         oy;
   logic signed [SW-1:0]         sum_x;
   logic signed [SW-1:0]         sum_y;
   logic signed [POS_BITS-1:0]   sat_x;
   logic signed [POS_BITS-1:0]   sat_y;
   side_type                     last_side;

   logic                         rsp_strobe_ff;
   rsp_type                      rsp_data_ff;
   rsp_type                      rsp_data_in;

   assign busy   = reset;
   assign accept = start && !busy;

   // stage 1: angle step and start-vector multiplies
   assign prod_in = req_data.orbit_speed * $signed({1'b0, req_data.delta_time});
   assign gain_in = PROD_BITS'(req_data.orbit_radius) * PROD_BITS'(GAIN_INV_Q30);

   always_comb begin
      s1_side_in.present = req_data.parent_present;
      s1_side_in.pending = req_data.already_pending;
      s1_side_in.angle   = req_data.current_angle;
      s1_side_in.px      = req_data.parent_x;
      s1_side_in.py      = req_data.parent_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_side_ff <= s1_side_in;
      s1_step_ff <= prod_in[FRAC_SHIFT +: ANGLE_BITS];
      s1_x0_ff   <= gain_in[PROD_BITS-1:GAIN_SHIFT];
   end

   // stage 2: wrap the angle, fold into the right half plane
   assign na     = s1_side_ff.angle + s1_step_ff;
   assign phase  = {na, {(PHASE_BITS-ANGLE_BITS){1'b0}}};
   assign flip   = phase[PHASE_BITS-1] ^ phase[PHASE_BITS-2];
   assign z_fold = flip ? {~phase[PHASE_BITS-1], phase[PHASE_BITS-2:0]} : phase;
   assign x_pos  = $signed({{(CW-X0_BITS){1'b0}}, s1_x0_ff});

   always_comb begin
      c_side_in[0]       = s1_side_ff;
      c_side_in[0].angle = na;
   end

   assign c_valid_in[0] = s1_valid_ff;
   assign c_x_in[0]     = flip ? -x_pos : x_pos;
   assign c_y_in[0]     = '0;
   assign c_z_in[0]     = ZW'($signed(z_fold));

   // CORDIC rotation stages
   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
      logic signed [CW-1:0] xt;
      logic signed [CW-1:0] yt;
      logic signed [ZW-1:0] zt;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic signed [ZW-1:0] at;

      always_comb begin
         xt = c_x_ff[g];
         yt = c_y_ff[g];
         zt = c_z_ff[g];
         dx = '0;
         dy = '0;
         at = '0;
         for (int k = 0; k < ITERS_PER_STAGE; k++) begin
            dx = yt >>> (g * ITERS_PER_STAGE + k);
            dy = xt >>> (g * ITERS_PER_STAGE + k);
            at = $signed(ZW'(cordic_atan(ITER_IDX_W'(g * ITERS_PER_STAGE + k))));
            if (!zt[ZW-1]) begin
               xt = xt - dx;
               yt = yt + dy;
               zt = zt - at;
            end else begin
               xt = xt + dx;
               yt = yt - dy;
               zt = zt + at;
            end
         end
      end

      assign c_valid_in[g+1] = c_valid_ff[g];
      assign c_side_in[g+1]  = c_side_ff[g];
      assign c_x_in[g+1]     = xt;
      assign c_y_in[g+1]     = yt;
      assign c_z_in[g+1]     = zt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= CORDIC_STAGES; s++) begin
            c_valid_ff[s] <= 1'b0;
         end
      end else begin
         for (int s = 0; s <= CORDIC_STAGES; s++) begin
            c_valid_ff[s] <= c_valid_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= CORDIC_STAGES; s++) begin
         c_side_ff[s] <= c_side_in[s];
         c_x_ff[s]    <= c_x_in[s];
         c_y_ff[s]    <= c_y_in[s];
         c_z_ff[s]    <= c_z_in[s];
      end
   end

   // output stage: round to Q19.0, add parent, saturate
   assign last_side = c_side_ff[CORDIC_STAGES];
   assign xr        = c_x_ff[CORDIC_STAGES] + $signed(ROUND_HALF);
   assign yr        = c_y_ff[CORDIC_STAGES] + $signed(ROUND_HALF);
   assign ox        = xr[CW-1:FRAC_SHIFT];
   assign oy        = yr[CW-1:FRAC_SHIFT];
   assign sum_x     = SW'(last_side.px) + SW'(ox);
   assign sum_y     = SW'(last_side.py) + SW'(oy);

   always_comb begin
      if (sum_x[SW-1:POS_BITS-1] == {(SW-POS_BITS+1){sum_x[SW-1]}}) begin
         sat_x = sum_x[POS_BITS-1:0];
      end else begin
         sat_x = {sum_x[SW-1], {(POS_BITS-1){~sum_x[SW-1]}}};
      end
      if (sum_y[SW-1:POS_BITS-1] == {(SW-POS_BITS+1){sum_y[SW-1]}}) begin
         sat_y = sum_y[POS_BITS-1:0];
      end else begin
         sat_y = {sum_y[SW-1], {(POS_BITS-1){~sum_y[SW-1]}}};
      end
   end

   always_comb begin
      if (last_side.present) begin
         rsp_data_in.new_angle       = last_side.angle;
         rsp_data_in.new_x           = sat_x;
         rsp_data_in.new_y           = sat_y;
         rsp_data_in.position_valid  = 1'b1;
         rsp_data_in.request_destroy = 1'b0;
      end else begin
         rsp_data_in.new_angle       = '0;
         rsp_data_in.new_x           = '0;
         rsp_data_in.new_y           = '0;
         rsp_data_in.position_valid  = 1'b0;
         rsp_data_in.request_destroy = !last_side.pending;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= c_valid_ff[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("request beat produced no response at the expected latency");

   a_destroy_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_data.request_destroy && rsp_data.position_valid))
      else $error("destroy request together with a valid position");

   a_missing_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.position_valid) |->
         (rsp_data.new_angle == '0 && rsp_data.new_x == '0 && rsp_data.new_y == '0))
      else $error("position fields not cleared for a missing parent");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> ##(LATENCY-1) !rsp_strobe)
      else $error("response beat without a request");

endmodule

>>> tb/sv/orbit_position_update_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orbit_position_update_tb
// Self-checking bench for the orbit position update block. A queue of bodies
// (a directed set of quadrant edges, wrap cases, clamping and missing parents,
// then random bodies) feeds a falling-edge driver with random idle bursts. A
// rising-edge monitor predicts each accepted beat with an independent angle
// step, CORDIC rotation and clamp, and compares every response field in order.
// ----------------------------------------------------------------------------
module orbit_position_update_tb;
   import opu_pkg::*;

   localparam int RANDOM_BODIES  = 1100;
   localparam int QUIET_TAIL     = 150;
   localparam int WATCHDOG_LIMIT = 500;
   localparam longint POS_MAX    = 64'sd8388607;
   localparam longint POS_MIN    = -64'sd8388608;
   localparam longint GAIN_Q30   = 64'sd652032874;
   localparam longint ARCTAN_Q32 [16] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   req_type bodies_to_send[$];
   rsp_type placements_due[$];
   rsp_type want;
   logic    beat_taken = 1'b0;
   int      idle_left = 0;
   int      idle_pct = 20;
   int      sent_count = 0;
   int      stall_cycles = 0;
   int      mismatches = 0;
   int      beats_in = 0;
   int      results_seen = 0;
   int      orphan_count = 0;
   int      clamp_count = 0;
   bit      timed_out = 1'b0;

   orbit_position_update uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic longint clamp_pos(input longint v);
      if (v > POS_MAX) return POS_MAX;
      if (v < POS_MIN) return POS_MIN;
      return v;
   endfunction

   function automatic rsp_type predict_orbit(input req_type b);
      rsp_type r;
      longint step, x, y, z, dx, dy, px, py;
      logic [ANGLE_BITS-1:0] na;
      logic [31:0] phase;
      r = '0;
      if (!b.parent_present) begin
         r.request_destroy = !b.already_pending;
         return r;
      end
      step = (longint'($signed(b.orbit_speed)) * longint'(b.delta_time)) >>> 16;
      na = b.current_angle + step[ANGLE_BITS-1:0];
      phase = {na, 16'h0000};
      x = (longint'(b.orbit_radius) * GAIN_Q30) >>> 14;
      y = 0;
      if (phase >= 32'h4000_0000 && phase < 32'hC000_0000) begin
         x = -x;
         z = longint'(phase) - 64'sh8000_0000;
      end else if (phase >= 32'h8000_0000) begin
         z = longint'(phase) - 64'sh1_0000_0000;
      end else begin
         z = longint'(phase);
      end
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ARCTAN_Q32[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ARCTAN_Q32[i];
         end
      end
      px = clamp_pos(longint'($signed(b.parent_x)) + ((x + 32768) >>> 16));
      py = clamp_pos(longint'($signed(b.parent_y)) + ((y + 32768) >>> 16));
      r.new_angle = na;
      r.new_x = px[POS_BITS-1:0];
      r.new_y = py[POS_BITS-1:0];
      r.position_valid = 1'b1;
      return r;
   endfunction

   function automatic req_type make_body(input logic present, input logic pending,
                                         input logic [23:0] px, input logic [23:0] py,
                                         input logic [15:0] ang, input logic [23:0] spd,
                                         input logic [15:0] dt, input logic [15:0] rad);
      req_type b;
      b.parent_present  = present;
      b.already_pending = pending;
      b.parent_x        = px;
      b.parent_y        = py;
      b.current_angle   = ang;
      b.orbit_speed     = spd;
      b.delta_time      = dt;
      b.orbit_radius    = rad;
      return b;
   endfunction

   function automatic logic [23:0] random_coord();
      case ($urandom_range(9))
         0: return 24'h7FFFFF - 24'($urandom_range('h18000));
         1: return 24'h800000 + 24'($urandom_range('h18000));
         default: return 24'($urandom());
      endcase
   endfunction

   function automatic req_type random_body();
      req_type b;
      b.parent_present  = ($urandom_range(9) != 0);
      b.already_pending = 1'($urandom_range(1));
      b.parent_x        = random_coord();
      b.parent_y        = random_coord();
      b.current_angle   = 16'($urandom());
      if ($urandom_range(3) == 0) b.orbit_speed = 24'($urandom_range(2000)) - 24'd1000;
      else b.orbit_speed = 24'($urandom());
      if ($urandom_range(1) == 0) b.delta_time = 16'($urandom_range(2000));
      else b.delta_time = 16'($urandom());
      case ($urandom_range(7))
         0: b.orbit_radius = 16'h0000;
         1: b.orbit_radius = 16'hFFFF;
         default: b.orbit_radius = 16'($urandom());
      endcase
      return b;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("MISMATCH at %0t: %s", $time, what);
   endtask

   // driver: advance when idle or on an accepted beat, hold otherwise
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || beat_taken) begin
         if (idle_left > 0) begin
            start <= 1'b0;
            idle_left <= idle_left - 1;
         end else if (bodies_to_send.size() > 0) begin
            req_data <= bodies_to_send.pop_front();
            start <= 1'b1;
            sent_count++;
            if (sent_count % 64 == 0) idle_pct = $urandom_range(2) * 20;
            if (bodies_to_send.size() > QUIET_TAIL && $urandom_range(99) < idle_pct)
               idle_left <= $urandom_range(11, 1);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: predict on each request beat, check each response beat
   always @(posedge clock) begin
      beat_taken <= start && !busy;
      if (!reset) begin
         if (start && !busy) begin
            placements_due.push_back(predict_orbit(req_data));
            beats_in++;
            if (!req_data.parent_present) orphan_count++;
         end
         if (rsp_strobe) begin
            results_seen++;
            if (placements_due.size() == 0) begin
               report_mismatch($sformatf("response %0d with nothing outstanding", results_seen));
            end else begin
               want = placements_due.pop_front();
               if (want.position_valid && (want.new_x == 24'sh7FFFFF || want.new_x == 24'sh800000
                   || want.new_y == 24'sh7FFFFF || want.new_y == 24'sh800000))
                  clamp_count++;
               if (rsp_data.new_angle !== want.new_angle)
                  report_mismatch($sformatf("response %0d new_angle %h, want %h",
                                            results_seen, rsp_data.new_angle, want.new_angle));
               if (rsp_data.new_x !== want.new_x)
                  report_mismatch($sformatf("response %0d new_x %0d, want %0d",
                                            results_seen, rsp_data.new_x, want.new_x));
               if (rsp_data.new_y !== want.new_y)
                  report_mismatch($sformatf("response %0d new_y %0d, want %0d",
                                            results_seen, rsp_data.new_y, want.new_y));
               if (rsp_data.position_valid !== want.position_valid)
                  report_mismatch($sformatf("response %0d position_valid %b, want %b",
                                            results_seen, rsp_data.position_valid,
                                            want.position_valid));
               if (rsp_data.request_destroy !== want.request_destroy)
                  report_mismatch($sformatf("response %0d request_destroy %b, want %b",
                                            results_seen, rsp_data.request_destroy,
                                            want.request_destroy));
            end
         end
         if ((start && !busy) || rsp_strobe) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      bodies_to_send.push_back(make_body(0, 0, 24'h7FFFFF, 24'h800000, 16'hFFFF,
                                         24'h7FFFFF, 16'hFFFF, 16'hFFFF));
      bodies_to_send.push_back(make_body(0, 1, 24'h800000, 24'h7FFFFF, 16'h8000,
                                         24'h800000, 16'hFFFF, 16'hFFFF));
      bodies_to_send.push_back(make_body(0, 0, '0, '0, '0, '0, '0, '0));
      bodies_to_send.push_back(make_body(1, 1, '0, '0, '0, '0, '0, 16'h0100));
      foreach (ARCTAN_Q32[i]) begin
         if (i < 8)
            bodies_to_send.push_back(make_body(1, 0, '0, '0,
               16'(i / 2) * 16'h4000 - 16'(i % 2), '0, '0, 16'h6400));
      end
      bodies_to_send.push_back(make_body(1, 0, 24'h001000, 24'hFFF000, 16'h1234,
                                         24'h012345, 16'h0444, 16'h0000));
      bodies_to_send.push_back(make_body(1, 0, '0, '0, 16'h0000, 24'h7FFFFF, 16'hFFFF,
                                         16'h3000));
      bodies_to_send.push_back(make_body(1, 0, '0, '0, 16'h0000, 24'h800000, 16'hFFFF,
                                         16'h3000));
      bodies_to_send.push_back(make_body(1, 0, '0, '0, 16'h0000, 24'hFFFFFF, 16'h0001,
                                         16'h3000));
      bodies_to_send.push_back(make_body(1, 0, 24'h7FFFFF, '0, 16'h0000, '0, '0, 16'hFFFF));
      bodies_to_send.push_back(make_body(1, 0, 24'h800000, '0, 16'h8000, '0, '0, 16'hFFFF));
      bodies_to_send.push_back(make_body(1, 0, '0, 24'h7FFFFF, 16'h4000, '0, '0, 16'hFFFF));
      bodies_to_send.push_back(make_body(1, 0, '0, 24'h800000, 16'hC000, '0, '0, 16'hFFFF));
      bodies_to_send.push_back(make_body(1, 0, 24'h800000, 24'h7FFFFF, 16'h6000,
                                         24'h000400, 16'h8000, 16'hFFFF));
      repeat (RANDOM_BODIES) bodies_to_send.push_back(random_body());

      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (!timed_out && (bodies_to_send.size() > 0 || start || placements_due.size() > 0))
      begin
         @(negedge clock);
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            report_mismatch($sformatf("no beat for %0d cycles, %0d responses outstanding",
                                      stall_cycles, placements_due.size()));
            timed_out = 1'b1;
         end
      end
      if (!timed_out) repeat (LATENCY + 5) @(negedge clock);

      $display("Covered %0d bodies: %0d with the parent missing, %0d with a clamped coordinate.",
               beats_in, orphan_count, clamp_count);
      $display("Checked %0d responses, %0d field mismatches.", results_seen, mismatches);
      if (mismatches == 0)
         $display("orbit_position_update: match");
      else
         $display("orbit_position_update: mismatch");
      $finish;
   end

endmodule
